// File: design/bilinear_frame_upscaler_unit_assert.svh
// Assertion macros used by the upscaler checker.
`ifndef BILINEAR_FRAME_UPSCALER_UNIT_ASSERT_SVH
`define BILINEAR_FRAME_UPSCALER_UNIT_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define BFU_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define BFU_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: design/bfu_pkg.sv
// Shared constants and controller/datapath interface types of the frame upscaler.
package bfu_pkg;

  localparam int unsigned SENSOR_COLS_DEF = 32;
  localparam int unsigned SENSOR_ROWS_DEF = 24;
  localparam int unsigned SCALE_X_DEF     = 10;
  localparam int unsigned SCALE_Y_DEF     = 10;
  localparam int unsigned STORE_DEPTH_DEF = SENSOR_COLS_DEF * SENSOR_ROWS_DEF;

  localparam int PIX_W = 16;
  localparam int IDX_W = 10;
  localparam int DX_W  = 9;
  localparam int DY_W  = 8;

  localparam logic CMD_WRITE = 1'b0;
  localparam logic CMD_READ  = 1'b1;

  localparam logic METHOD_BILINEAR = 1'b0;
  localparam logic METHOD_NEAREST  = 1'b1;

  typedef struct packed {
    logic       wr;
    logic       cap;
    logic       div;
    logic       rem;
    logic       addr;
    logic       rd;
    logic [1:0] rd_sel;
    logic       take;
    logic [1:0] take_sel;
    logic       vmul0;
    logic       vmul1;
    logic       rnd;
    logic       rcp;
    logic       fix;
    logic       load;
  } bfu_cmd_t;

  typedef struct packed {
    logic in_range;
  } bfu_sts_t;

endpackage

// File: design/bfu_ram.sv
// Generic single-port RAM with registered read.
module bfu_ram #(
  parameter int unsigned WIDTH = bfu_pkg::PIX_W,
  parameter int unsigned DEPTH = bfu_pkg::STORE_DEPTH_DEF
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] addr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[addr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// File: design/bfu_datapath.sv
// Datapath of the frame upscaler: frame memory, coordinate split, weighting, rounding.
module bfu_datapath #(
  parameter int unsigned SENSOR_COLS = bfu_pkg::SENSOR_COLS_DEF,
  parameter int unsigned SENSOR_ROWS = bfu_pkg::SENSOR_ROWS_DEF,
  parameter int unsigned SCALE_X     = bfu_pkg::SCALE_X_DEF,
  parameter int unsigned SCALE_Y     = bfu_pkg::SCALE_Y_DEF
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  bfu_pkg::bfu_cmd_t                cmd_i,
  output bfu_pkg::bfu_sts_t                sts_o,
  input  logic [bfu_pkg::IDX_W-1:0]        pixel_index_i,
  input  logic signed [bfu_pkg::PIX_W-1:0] pixel_value_i,
  input  logic [bfu_pkg::DX_W-1:0]         disp_col_i,
  input  logic [bfu_pkg::DY_W-1:0]         display_y_i,
  input  logic                             cfg_we_i,
  input  logic                             cfg_data_i,
  output logic signed [bfu_pkg::PIX_W-1:0] pixel_out_o,
  output logic                             in_range_o
);

  localparam int PIX_W  = bfu_pkg::PIX_W;
  localparam int DX_W   = bfu_pkg::DX_W;
  localparam int DY_W   = bfu_pkg::DY_W;
  localparam int DEPTH  = SENSOR_COLS * SENSOR_ROWS;
  localparam int AW     = $clog2(DEPTH);
  localparam int DISP_W = SENSOR_COLS * SCALE_X;
  localparam int DISP_H = SENSOR_ROWS * SCALE_Y;
  localparam int WX_W   = $clog2(SCALE_X + 1);
  localparam int WY_W   = $clog2(SCALE_Y + 1);
  // reciprocal constants for the coordinate split
  localparam int RX_S   = DX_W;
  localparam int RX_M   = (2 ** RX_S) / SCALE_X;
  localparam int RX_PW  = DX_W + RX_S + 1;
  localparam int RY_S   = DY_W;
  localparam int RY_M   = (2 ** RY_S) / SCALE_Y;
  localparam int RY_PW  = DY_W + RY_S + 1;
  // weighted sums and the final rounding divide
  localparam int TOP_W  = PIX_W + WX_W;
  localparam int NUM_W  = TOP_W + WY_W;
  localparam int DIV_D  = SCALE_X * SCALE_Y;
  localparam int A_W    = NUM_W + 1;
  localparam int RC_S   = A_W;
  localparam int RC_M   = (2 ** RC_S) / DIV_D;
  localparam int RC_PW  = A_W + RC_S + 1;

  logic                    method_q;
  logic [DX_W-1:0]         dx_q;
  logic [DY_W-1:0]         dy_q;
  logic                    rng_q;
  logic [DX_W-1:0]         qx_q;
  logic [DY_W-1:0]         qy_q;
  logic [WX_W-1:0]         rx_q;
  logic [WY_W-1:0]         ry_q;
  logic [AW-1:0]           base_q;
  logic                    stepx_q;
  logic                    stepy_q;
  logic signed [PIX_W-1:0] p00_q;
  logic signed [TOP_W-1:0] top_q;
  logic signed [TOP_W-1:0] bot_q;
  logic signed [NUM_W-1:0] num_q;
  logic                    neg_q;
  logic [A_W-1:0]          a_q;
  logic [A_W-1:0]          qe_q;
  logic signed [PIX_W-1:0] res_q;
  logic signed [PIX_W-1:0] pix_out_q;
  logic                    rng_out_q;

  logic                    rng_d;
  logic [RX_PW-1:0]        px_prod;
  logic [RY_PW-1:0]        py_prod;
  logic [DX_W-1:0]         rxw;
  logic [DY_W-1:0]         ryw;
  logic [DX_W-1:0]         x0_d;
  logic [DY_W-1:0]         y0_d;
  logic [WX_W-1:0]         rx_d;
  logic [WY_W-1:0]         ry_d;
  logic [AW-1:0]           base_d;
  logic                    stepx_d;
  logic                    stepy_d;
  logic [AW-1:0]           rd_addr;
  logic [AW-1:0]           ram_addr;
  logic                    ram_we;
  logic signed [PIX_W-1:0] rdata;
  logic [WX_W-1:0]         hw;
  logic signed [TOP_W-1:0] hprod;
  logic [WY_W-1:0]         vw;
  logic signed [TOP_W-1:0] vsrc;
  logic signed [NUM_W-1:0] vprod;
  logic [NUM_W-1:0]        mag;
  logic [A_W-1:0]          a_d;
  logic [RC_PW-1:0]        rc_prod;
  logic [A_W-1:0]          rr;
  logic [A_W-1:0]          qf;
  logic signed [PIX_W-1:0] res_d;

  // interpolation method register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      method_q <= bfu_pkg::METHOD_BILINEAR;
    end else if (cfg_we_i) begin
      method_q <= cfg_data_i;
    end
  end

  assign rng_d = (32'(disp_col_i) < 32'(DISP_W)) && (32'(display_y_i) < 32'(DISP_H));

  // quotient estimate, low by at most one
  assign px_prod = RX_PW'(dx_q) * RX_PW'(RX_M);
  assign py_prod = RY_PW'(dy_q) * RY_PW'(RY_M);

  always_comb begin
    rxw = dx_q - DX_W'(qx_q * DX_W'(SCALE_X));
    ryw = dy_q - DY_W'(qy_q * DY_W'(SCALE_Y));
    if (rxw >= DX_W'(SCALE_X)) begin
      x0_d = qx_q + DX_W'(1);
      rx_d = WX_W'(rxw - DX_W'(SCALE_X));
    end else begin
      x0_d = qx_q;
      rx_d = WX_W'(rxw);
    end
    if (ryw >= DY_W'(SCALE_Y)) begin
      y0_d = qy_q + DY_W'(1);
      ry_d = WY_W'(ryw - DY_W'(SCALE_Y));
    end else begin
      y0_d = qy_q;
      ry_d = WY_W'(ryw);
    end
  end

  assign base_d  = AW'(AW'(qy_q) * AW'(SENSOR_COLS) + AW'(qx_q));
  // repeat the edge pixel past the last column or row
  assign stepx_d = (32'(qx_q) + 32'd1) < 32'(SENSOR_COLS);
  assign stepy_d = (32'(qy_q) + 32'd1) < 32'(SENSOR_ROWS);

  assign rd_addr = base_q + AW'(cmd_i.rd_sel[0] & stepx_q)
                 + ((cmd_i.rd_sel[1] && stepy_q) ? AW'(SENSOR_COLS) : '0);
  assign ram_we   = cmd_i.wr && (32'(pixel_index_i) < 32'(DEPTH));
  assign ram_addr = cmd_i.wr ? AW'(pixel_index_i) : rd_addr;

  bfu_ram #(
    .WIDTH (PIX_W),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .re_i    (cmd_i.rd),
    .addr_i  (ram_addr),
    .wdata_i (pixel_value_i),
    .rdata_o (rdata)
  );

  // horizontal weighting of the pixel that just arrived
  assign hw    = cmd_i.take_sel[0] ? rx_q : (WX_W'(SCALE_X) - rx_q);
  assign hprod = TOP_W'(signed'({1'b0, hw})) * TOP_W'(rdata);

  // vertical weighting of the two row sums
  assign vw    = cmd_i.vmul1 ? ry_q : (WY_W'(SCALE_Y) - ry_q);
  assign vsrc  = cmd_i.vmul1 ? bot_q : top_q;
  assign vprod = NUM_W'(signed'({1'b0, vw})) * NUM_W'(vsrc);

  assign mag = num_q[NUM_W-1] ? unsigned'(-num_q) : unsigned'(num_q);
  assign a_d = A_W'(mag) + A_W'(DIV_D / 2);

  assign rc_prod = RC_PW'(a_q) * RC_PW'(RC_M);

  always_comb begin
    rr    = a_q - A_W'(qe_q * A_W'(DIV_D));
    qf    = qe_q + A_W'(rr >= A_W'(DIV_D));
    res_d = neg_q ? signed'(PIX_W'(-qf)) : signed'(PIX_W'(qf));
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.cap) begin
      dx_q  <= disp_col_i;
      dy_q  <= display_y_i;
      rng_q <= rng_d;
    end
    if (cmd_i.div) begin
      qx_q <= px_prod[RX_S +: DX_W];
      qy_q <= py_prod[RY_S +: DY_W];
    end
    if (cmd_i.rem) begin
      qx_q <= x0_d;
      qy_q <= y0_d;
      rx_q <= rx_d;
      ry_q <= ry_d;
    end
    if (cmd_i.addr) begin
      base_q  <= base_d;
      stepx_q <= stepx_d;
      stepy_q <= stepy_d;
    end
    if (cmd_i.take) begin
      case (cmd_i.take_sel)
        2'd0: begin
          top_q <= hprod;
          p00_q <= rdata;
        end
        2'd1: top_q <= top_q + hprod;
        2'd2: bot_q <= hprod;
        default: bot_q <= bot_q + hprod;
      endcase
    end
    if (cmd_i.vmul0) begin
      num_q <= vprod;
    end
    if (cmd_i.vmul1) begin
      num_q <= num_q + vprod;
    end
    if (cmd_i.rnd) begin
      neg_q <= num_q[NUM_W-1];
      a_q   <= a_d;
    end
    if (cmd_i.rcp) begin
      qe_q <= rc_prod[RC_S +: A_W];
    end
    if (cmd_i.fix) begin
      res_q <= res_d;
    end
    if (cmd_i.load) begin
      rng_out_q <= rng_q;
      if (!rng_q) begin
        pix_out_q <= '0;
      end else if (method_q == bfu_pkg::METHOD_NEAREST) begin
        pix_out_q <= p00_q;
      end else begin
        pix_out_q <= res_q;
      end
    end
  end

  assign sts_o.in_range = rng_q;
  assign pixel_out_o    = pix_out_q;
  assign in_range_o     = rng_out_q;

endmodule

// File: design/bfu_ctrl.sv
// Controller of the frame upscaler: sequences one request through the datapath.
module bfu_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  input  logic              command_i,
  output logic              in_stall_o,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output bfu_pkg::bfu_cmd_t cmd_o,
  input  bfu_pkg::bfu_sts_t sts_i
);

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DIV,
    ST_REM,
    ST_ADDR,
    ST_RD0,
    ST_RD1,
    ST_RD2,
    ST_RD3,
    ST_TK3,
    ST_VM0,
    ST_VM1,
    ST_RND,
    ST_RCP,
    ST_FIX,
    ST_OUT
  } state_e;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;

  always_comb begin
    cmd_o       = '0;
    state_d     = state_q;
    out_valid_d = out_valid_q && out_stall_i;
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          unique case (command_i)
            bfu_pkg::CMD_WRITE: cmd_o.wr = 1'b1;
            bfu_pkg::CMD_READ: begin
              cmd_o.cap = 1'b1;
              state_d   = ST_DIV;
            end
            default: state_d = ST_IDLE;
          endcase
        end
      end
      ST_DIV: begin
        cmd_o.div = 1'b1;
        state_d   = sts_i.in_range ? ST_REM : ST_OUT;
      end
      ST_REM: begin
        cmd_o.rem = 1'b1;
        state_d   = ST_ADDR;
      end
      ST_ADDR: begin
        cmd_o.addr = 1'b1;
        state_d    = ST_RD0;
      end
      ST_RD0: begin
        cmd_o.rd     = 1'b1;
        cmd_o.rd_sel = 2'd0;
        state_d      = ST_RD1;
      end
      ST_RD1: begin
        cmd_o.rd       = 1'b1;
        cmd_o.rd_sel   = 2'd1;
        cmd_o.take     = 1'b1;
        cmd_o.take_sel = 2'd0;
        state_d        = ST_RD2;
      end
      ST_RD2: begin
        cmd_o.rd       = 1'b1;
        cmd_o.rd_sel   = 2'd2;
        cmd_o.take     = 1'b1;
        cmd_o.take_sel = 2'd1;
        state_d        = ST_RD3;
      end
      ST_RD3: begin
        cmd_o.rd       = 1'b1;
        cmd_o.rd_sel   = 2'd3;
        cmd_o.take     = 1'b1;
        cmd_o.take_sel = 2'd2;
        state_d        = ST_TK3;
      end
      ST_TK3: begin
        cmd_o.take     = 1'b1;
        cmd_o.take_sel = 2'd3;
        state_d        = ST_VM0;
      end
      ST_VM0: begin
        cmd_o.vmul0 = 1'b1;
        state_d     = ST_VM1;
      end
      ST_VM1: begin
        cmd_o.vmul1 = 1'b1;
        state_d     = ST_RND;
      end
      ST_RND: begin
        cmd_o.rnd = 1'b1;
        state_d   = ST_RCP;
      end
      ST_RCP: begin
        cmd_o.rcp = 1'b1;
        state_d   = ST_FIX;
      end
      ST_FIX: begin
        cmd_o.fix = 1'b1;
        state_d   = ST_OUT;
      end
      ST_OUT: begin
        // hold until the output register is free
        if (!out_valid_q || !out_stall_i) begin
          cmd_o.load  = 1'b1;
          out_valid_d = 1'b1;
          state_d     = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign in_stall_o  = (state_q != ST_IDLE);
  assign out_valid_o = out_valid_q;

endmodule

// File: design/bilinear_frame_upscaler_unit.sv
// Top level of the bilinear frame upscaler: controller, datapath and method register port.
//
//  channel  direction  handshake                 payload
//  -------  ---------  ------------------------  ---------------------------------------------
//  in       sink       in_valid_i / in_stall_o   command, pixel_index, pixel_value, disp_col,
//                                                display_y
//  out      source     out_valid_o / out_stall_i pixel_out, in_range
//  cfg      sink       cfg_valid_i / cfg_ready_o cfg_data_i (method: 0 bilinear, 1 nearest)
//
//  A write is stored at its transfer edge; the next item may follow in the next cycle.
//  A read inside the display occupies the unit for its transfer cycle and 14 steps:
//  coordinate split, four reads of the single-port frame memory, weighting, rounding.
//  A read outside the display skips to the output step. New items are taken while a result
//  waits in the output register; a stalled result holds the next read in its last step.
//  Reset clears the controller and the method register, not the frame memory.
module bilinear_frame_upscaler_unit #(
  parameter int unsigned SENSOR_COLS = bfu_pkg::SENSOR_COLS_DEF,
  parameter int unsigned SENSOR_ROWS = bfu_pkg::SENSOR_ROWS_DEF,
  parameter int unsigned SCALE_X     = bfu_pkg::SCALE_X_DEF,
  parameter int unsigned SCALE_Y     = bfu_pkg::SCALE_Y_DEF
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  // request channel
  input  logic                             in_valid_i,
  output logic                             in_stall_o,
  input  logic                             command_i,
  input  logic [bfu_pkg::IDX_W-1:0]        pixel_index_i,
  input  logic signed [bfu_pkg::PIX_W-1:0] pixel_value_i,
  input  logic [bfu_pkg::DX_W-1:0]         disp_col_i,
  input  logic [bfu_pkg::DY_W-1:0]         display_y_i,
  // result channel
  output logic                             out_valid_o,
  input  logic                             out_stall_i,
  output logic signed [bfu_pkg::PIX_W-1:0] pixel_out_o,
  output logic                             in_range_o,
  // method register write
  input  logic                             cfg_valid_i,
  output logic                             cfg_ready_o,
  input  logic                             cfg_data_i
);

  bfu_pkg::bfu_cmd_t cmd;
  bfu_pkg::bfu_sts_t sts;

  // the method register takes a write in any cycle
  assign cfg_ready_o = 1'b1;

  // sequence each read through the datapath, one item at a time
  bfu_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .command_i   (command_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .cmd_o       (cmd),
    .sts_i       (sts)
  );

  // frame memory, weighting and rounding; also owns the output register
  bfu_datapath #(
    .SENSOR_COLS (SENSOR_COLS),
    .SENSOR_ROWS (SENSOR_ROWS),
    .SCALE_X     (SCALE_X),
    .SCALE_Y     (SCALE_Y)
  ) u_datapath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .sts_o         (sts),
    .pixel_index_i (pixel_index_i),
    .pixel_value_i (pixel_value_i),
    .disp_col_i    (disp_col_i),
    .display_y_i   (display_y_i),
    .cfg_we_i      (cfg_valid_i & cfg_ready_o),
    .cfg_data_i    (cfg_data_i),
    .pixel_out_o   (pixel_out_o),
    .in_range_o    (in_range_o)
  );

endmodule

// File: design/bfu_checker.sv
// Port-level checker of the frame upscaler and its bind to the top level.
`include "bilinear_frame_upscaler_unit_assert.svh"

module bfu_checker (
  input logic                             clk_i,
  input logic                             rst_ni,
  input logic                             in_valid_i,
  input logic                             in_stall_o,
  input logic                             command_i,
  input logic                             out_valid_o,
  input logic                             out_stall_i,
  input logic signed [bfu_pkg::PIX_W-1:0] pixel_out_o,
  input logic                             in_range_o
);

  `BFU_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_valid_o && out_stall_i, out_valid_o && $stable(pixel_out_o) && $stable(in_range_o), "stalled result changed")
  `BFU_ASSERT_NOW(a_oor_zero, clk_i, rst_ni, out_valid_o && !in_range_o, pixel_out_o == '0, "out of range result not zero")
  `BFU_ASSERT_NEXT(a_read_busy, clk_i, rst_ni, in_valid_i && !in_stall_o && command_i == bfu_pkg::CMD_READ, in_stall_o, "read transfer did not occupy the unit")
  `BFU_ASSERT_NEXT(a_write_free, clk_i, rst_ni, in_valid_i && !in_stall_o && command_i == bfu_pkg::CMD_WRITE, !in_stall_o, "write transfer stalled the next item")

endmodule

bind bilinear_frame_upscaler_unit bfu_checker u_checker (.*);
